// ----- sv/bpc_pkg.sv -----
// Shared types, constants and helpers of the balance PID controller.
package bpc_pkg;

	typedef struct packed {
		logic signed [15:0] accel_z;
		logic signed [15:0] gyro_pitch;
		logic signed [15:0] gyro_roll;
		logic signed [15:0] wheel_speed;
		logic [2:0]         action;
	} in_word_t;

	typedef struct packed {
		logic signed [23:0] left_accel;
		logic signed [23:0] right_accel;
		logic               drive_positive;
		logic signed [15:0] tilt_estimate;
	} out_word_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_AZ, ST_AANG, ST_TGT, ST_INNER, ST_MIX0, ST_MIX1, ST_TILT,
		ST_ERR, ST_BP, ST_BD, ST_BI, ST_BAL, ST_TD, ST_TACC, ST_TURN, ST_DONE
	} state_t;

	// register indexes
	localparam logic [2:0] REG_BAL_KP  = 3'd0;
	localparam logic [2:0] REG_BAL_KI  = 3'd1;
	localparam logic [2:0] REG_BAL_KD  = 3'd2;
	localparam logic [2:0] REG_SPD_KP  = 3'd3;
	localparam logic [2:0] REG_TURN_KP = 3'd4;
	localparam logic [2:0] REG_TURN_KD = 3'd5;
	localparam logic [2:0] REG_BLEND   = 3'd6;
	localparam logic [2:0] REG_UPRIGHT = 3'd7;

	// motion commands
	localparam logic [2:0] ACT_FWD  = 3'd0;
	localparam logic [2:0] ACT_REV  = 3'd1;
	localparam logic [2:0] ACT_CW   = 3'd2;
	localparam logic [2:0] ACT_ACW  = 3'd3;
	localparam logic [2:0] ACT_STOP = 3'd4;
	localparam logic [2:0] ACT_NONE = 3'd5;

	localparam logic [31:0] BAL_KP_RST  = 32'd131072000;
	localparam logic [31:0] BAL_KI_RST  = 32'd327680;
	localparam logic [31:0] BAL_KD_RST  = 32'd4259840;
	localparam logic [31:0] SPD_KP_RST  = 32'd131;
	localparam logic [31:0] TURN_KP_RST = 32'd655360;
	localparam logic [31:0] TURN_KD_RST = 32'd524288;
	localparam logic [15:0] BLEND_RST   = 16'd64225;
	localparam logic [14:0] UPRIGHT_RST = 15'd82;

	localparam int MUL_W = 33;

	localparam logic signed [MUL_W-1:0] AZ_SCALE = 33'sd27109;
	localparam logic signed [MUL_W-1:0] DT_Q16   = 33'sd328;
	localparam logic signed [16:0] ACCEL_OFS = 17'sd147;
	localparam logic signed [16:0] SPIN_OFS  = 17'sd4;
	localparam logic signed [16:0] PITCH_OFS = 17'sd82;
	localparam logic signed [63:0] SPEED_OFS = 64'sd16;
	localparam logic signed [15:0] FWD_SPEED = -16'sd7168;
	localparam logic signed [15:0] REV_SPEED = 16'sd9216;
	localparam logic signed [24:0] QUARTER   = 25'sd6431;

	function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
		if (v > 64'sd32767) begin
			return 16'sh7fff;
		end else if (v < -64'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
		if (v > 64'sd8388607) begin
			return 24'sh7fffff;
		end else if (v < -64'sd8388608) begin
			return 24'sh800000;
		end
		return v[23:0];
	endfunction

endpackage

// ----- sv/bpc_mul.sv -----
// Shared signed multiplier with registered product.
module bpc_mul (
	input  logic                                  clk,
	input  logic signed [bpc_pkg::MUL_W-1:0]      a,
	input  logic signed [bpc_pkg::MUL_W-1:0]      b,
	output logic signed [2*bpc_pkg::MUL_W-1:0]    p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

// ----- sv/balance_pid_controller_core.sv -----
// Top level of the balance PID controller: sequencer, state and output register.
//
//  channel | signals                          | moves
//  --------+----------------------------------+-------------------------------
//  in      | in_valid, in_ready, in_word      | one control tick word
//  out     | out_valid, out_ready, out_word   | one wheel command word per tick
//  cfg     | cfg_wen, cfg_index, cfg_data     | one gain/threshold write
//
// Each word runs through the sequencer states from accept to result, and the next
// word is accepted only once the sequencer is back in idle: one 33x33 multiplier is
// stepped through eleven products by the sequencer, one per cycle.
// A result waiting in the output register does not block the next accept;
// only the final step holds while that register is still full.
// Reset clears the filter, heading, error and setpoint state and sets both turn
// latches; registers return to their default gains.
module balance_pid_controller_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bpc_pkg::in_word_t   in_word,
	output logic                out_valid,
	input  logic                out_ready,
	output bpc_pkg::out_word_t  out_word,
	input  logic                cfg_wen,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	localparam int W = bpc_pkg::MUL_W;

	bpc_pkg::state_t state_q, state_d;

	// configuration
	logic [31:0] bal_kp_q, bal_ki_q, bal_kd_q, spd_kp_q, turn_kp_q, turn_kd_q;
	logic [15:0] blend_q;
	logic [14:0] upright_q;

	// controller state carried between ticks
	logic signed [15:0] tilt_state_q;
	logic signed [23:0] heading_state_q;
	logic signed [16:0] last_be_q;
	logic signed [23:0] last_te_q;
	logic signed [15:0] speed_sp_q;
	logic signed [23:0] turn_sp_q;
	logic [1:0]         latch_q;

	// per-tick working registers
	bpc_pkg::in_word_t  in_q;
	logic signed [16:0] aa_q;
	logic signed [15:0] target_q;
	logic signed [32:0] inner_q;
	logic signed [63:0] acc_q;
	logic signed [15:0] tilt_q;
	logic signed [23:0] heading_q;
	logic signed [16:0] e_q;
	logic signed [23:0] terr_q;
	logic signed [23:0] tdiff_q;
	logic signed [25:0] dd_q;
	logic signed [26:0] sp_q;
	logic signed [32:0] td200_q;
	logic signed [23:0] bal_q;
	logic signed [23:0] turn_q;

	bpc_pkg::out_word_t out_q;
	logic               out_valid_q;

	logic signed [W-1:0]   mul_a, mul_b;
	logic signed [2*W-1:0] p_q;
	logic signed [63:0]    p64;
	logic                  finish;

	assign p64 = p_q[63:0];

	bpc_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p_q)
	);

	assign in_ready  = (state_q == bpc_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	// Sequencer: one step a cycle, hold at the end while the output is full.
	always_comb begin
		state_d = state_q;
		finish  = 1'b0;
		case (state_q)
			bpc_pkg::ST_IDLE:  if (in_valid) state_d = bpc_pkg::ST_AZ;
			bpc_pkg::ST_AZ:    state_d = bpc_pkg::ST_AANG;
			bpc_pkg::ST_AANG:  state_d = bpc_pkg::ST_TGT;
			bpc_pkg::ST_TGT:   state_d = bpc_pkg::ST_INNER;
			bpc_pkg::ST_INNER: state_d = bpc_pkg::ST_MIX0;
			bpc_pkg::ST_MIX0:  state_d = bpc_pkg::ST_MIX1;
			bpc_pkg::ST_MIX1:  state_d = bpc_pkg::ST_TILT;
			bpc_pkg::ST_TILT:  state_d = bpc_pkg::ST_ERR;
			bpc_pkg::ST_ERR:   state_d = bpc_pkg::ST_BP;
			bpc_pkg::ST_BP:    state_d = bpc_pkg::ST_BD;
			bpc_pkg::ST_BD:    state_d = bpc_pkg::ST_BI;
			bpc_pkg::ST_BI:    state_d = bpc_pkg::ST_BAL;
			bpc_pkg::ST_BAL:   state_d = bpc_pkg::ST_TD;
			bpc_pkg::ST_TD:    state_d = bpc_pkg::ST_TACC;
			bpc_pkg::ST_TACC:  state_d = bpc_pkg::ST_TURN;
			bpc_pkg::ST_TURN:  state_d = bpc_pkg::ST_DONE;
			bpc_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					finish  = 1'b1;
					state_d = bpc_pkg::ST_IDLE;
				end
			end
			default: state_d = bpc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Multiplier operands; the product is registered in p_q for the next step.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			bpc_pkg::ST_AZ: begin
				mul_a = W'(in_q.accel_z);
				mul_b = bpc_pkg::AZ_SCALE;
			end
			bpc_pkg::ST_AANG: begin
				mul_a = W'(17'(speed_sp_q) - 17'(in_q.wheel_speed));
				mul_b = $signed({1'b0, spd_kp_q});
			end
			bpc_pkg::ST_TGT: begin
				mul_a = W'(17'(in_q.gyro_pitch) - bpc_pkg::PITCH_OFS);
				mul_b = bpc_pkg::DT_Q16;
			end
			bpc_pkg::ST_INNER: begin
				mul_a = W'(aa_q);
				mul_b = W'($signed(18'h10000 - {2'b00, blend_q}));
			end
			bpc_pkg::ST_MIX0: begin
				mul_a = inner_q;
				mul_b = $signed({17'd0, blend_q});
			end
			bpc_pkg::ST_MIX1: begin
				mul_a = W'(17'(in_q.gyro_roll) + bpc_pkg::SPIN_OFS);
				mul_b = bpc_pkg::DT_Q16;
			end
			bpc_pkg::ST_BP: begin
				mul_a = W'(e_q);
				mul_b = $signed({1'b0, bal_kp_q});
			end
			bpc_pkg::ST_BD: begin
				mul_a = W'(dd_q);
				mul_b = $signed({1'b0, bal_kd_q});
			end
			bpc_pkg::ST_BI: begin
				mul_a = W'(sp_q);
				mul_b = $signed({1'b0, bal_ki_q});
			end
			bpc_pkg::ST_BAL: begin
				mul_a = W'(terr_q);
				mul_b = $signed({1'b0, turn_kp_q});
			end
			bpc_pkg::ST_TD: begin
				mul_a = td200_q;
				mul_b = $signed({1'b0, turn_kd_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Working registers: a step that uses a product takes the one issued by the step before.
	always_ff @(posedge clk) begin
		case (state_q)
			bpc_pkg::ST_IDLE: begin
				if (in_valid) in_q <= in_word;
			end
			bpc_pkg::ST_AANG: begin
				aa_q <= 17'((p64 + 64'sd32768) >>> 16) - bpc_pkg::ACCEL_OFS;
			end
			bpc_pkg::ST_TGT: begin
				target_q <= bpc_pkg::sat16(((p64 + 64'sd8192) >>> 14) - bpc_pkg::SPEED_OFS);
			end
			bpc_pkg::ST_INNER: begin
				inner_q <= p_q[32:0] + {tilt_state_q[15], tilt_state_q, 16'd0};
			end
			bpc_pkg::ST_MIX0: begin
				acc_q <= p64 <<< 16;
			end
			bpc_pkg::ST_MIX1: begin
				acc_q <= acc_q + p64;
			end
			bpc_pkg::ST_TILT: begin
				// round the Q.44 mix to Q4.12, fold in this tick's spin
				tilt_q    <= bpc_pkg::sat16((acc_q + 64'sh80000000) >>> 32);
				heading_q <= bpc_pkg::sat24(64'(heading_state_q)
					+ ((p64 + 64'sd32768) >>> 16));
			end
			bpc_pkg::ST_ERR: begin
				e_q    <= 17'(target_q) - 17'(tilt_q);
				terr_q <= bpc_pkg::sat24(64'(turn_sp_q) - 64'(heading_q));
			end
			bpc_pkg::ST_BP: begin
				dd_q    <= -(26'(18'(e_q) - 18'(last_be_q)) * 26'sd200);
				sp_q    <= 27'(18'(e_q) + 18'(last_be_q)) * 27'sd328;
				tdiff_q <= bpc_pkg::sat24(64'(terr_q) - 64'(last_te_q));
			end
			bpc_pkg::ST_BD: begin
				acc_q   <= p64;
				td200_q <= 33'(tdiff_q) * 33'sd200;
			end
			bpc_pkg::ST_BI: begin
				acc_q <= acc_q + p64;
			end
			bpc_pkg::ST_BAL: begin
				acc_q <= acc_q + ((p64 + 64'sd32768) >>> 16);
			end
			bpc_pkg::ST_TD: begin
				bal_q <= bpc_pkg::sat24((acc_q + 64'sd524288) >>> 20);
				acc_q <= p64;
			end
			bpc_pkg::ST_TACC: begin
				acc_q <= acc_q + p64;
			end
			bpc_pkg::ST_TURN: begin
				turn_q <= bpc_pkg::sat24((acc_q + 64'sd524288) >>> 20);
			end
			default: begin
			end
		endcase
	end

	// Mix balance and turn terms into the wheel commands; the turn term is left out once |tilt| reaches upright_q.
	logic signed [24:0] mag;
	logic signed [23:0] left_d, right_d;

	always_comb begin
		mag = tilt_q[15] ? -25'(tilt_q) : 25'(tilt_q);
		if (mag < $signed({10'd0, upright_q})) begin
			left_d  = bpc_pkg::sat24(-64'(bal_q) - 64'(turn_q));
			right_d = bpc_pkg::sat24(64'(bal_q) - 64'(turn_q));
		end else begin
			left_d  = bpc_pkg::sat24(-64'(bal_q));
			right_d = bal_q;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_q.left_accel     <= left_d;
			out_q.right_accel    <= right_d;
			out_q.drive_positive <= (bal_q > 24'sd0);
			out_q.tilt_estimate  <= tilt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Commit tick state and apply the command for the next tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tilt_state_q    <= '0;
			heading_state_q <= '0;
			last_be_q       <= '0;
			last_te_q       <= '0;
			speed_sp_q      <= '0;
			turn_sp_q       <= '0;
			latch_q         <= 2'b11;
		end else if (finish) begin
			tilt_state_q    <= tilt_q;
			heading_state_q <= heading_q;
			last_be_q       <= e_q;
			last_te_q       <= terr_q;
			case (in_q.action)
				bpc_pkg::ACT_FWD: begin
					speed_sp_q <= bpc_pkg::FWD_SPEED;
					latch_q    <= 2'b00;
				end
				bpc_pkg::ACT_REV: begin
					speed_sp_q <= bpc_pkg::REV_SPEED;
					latch_q    <= 2'b00;
				end
				bpc_pkg::ACT_CW: begin
					if (!latch_q[0]) begin
						turn_sp_q <= bpc_pkg::sat24(64'(turn_sp_q) + 64'(bpc_pkg::QUARTER));
						latch_q   <= 2'b01;
					end
				end
				bpc_pkg::ACT_ACW: begin
					if (!latch_q[1]) begin
						turn_sp_q <= bpc_pkg::sat24(64'(turn_sp_q) - 64'(bpc_pkg::QUARTER));
						latch_q   <= 2'b10;
					end
				end
				bpc_pkg::ACT_STOP: begin
					speed_sp_q <= '0;
					latch_q    <= 2'b00;
				end
				default: begin
				end
			endcase
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bal_kp_q  <= bpc_pkg::BAL_KP_RST;
			bal_ki_q  <= bpc_pkg::BAL_KI_RST;
			bal_kd_q  <= bpc_pkg::BAL_KD_RST;
			spd_kp_q  <= bpc_pkg::SPD_KP_RST;
			turn_kp_q <= bpc_pkg::TURN_KP_RST;
			turn_kd_q <= bpc_pkg::TURN_KD_RST;
			blend_q   <= bpc_pkg::BLEND_RST;
			upright_q <= bpc_pkg::UPRIGHT_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				bpc_pkg::REG_BAL_KP:  bal_kp_q  <= cfg_data;
				bpc_pkg::REG_BAL_KI:  bal_ki_q  <= cfg_data;
				bpc_pkg::REG_BAL_KD:  bal_kd_q  <= cfg_data;
				bpc_pkg::REG_SPD_KP:  spd_kp_q  <= cfg_data;
				bpc_pkg::REG_TURN_KP: turn_kp_q <= cfg_data;
				bpc_pkg::REG_TURN_KD: turn_kd_q <= cfg_data;
				bpc_pkg::REG_BLEND:   blend_q   <= cfg_data[15:0];
				bpc_pkg::REG_UPRIGHT: upright_q <= cfg_data[14:0];
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- sv/bpc_checker.sv -----
// Port-level checks of the balance PID controller, bound to the top level.
module bpc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input bpc_pkg::out_word_t out_word
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("output word changed while stalled");

	// busy after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted twice in a row");

	// no result can appear the cycle after an accept
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared too early");

	// a new result comes only from a word in progress
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without a word in progress");

endmodule

bind balance_pid_controller_core bpc_checker u_bpc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_word  (out_word)
);
